// ----- src/fra_pkg.sv -----
// Shared types and constants for the mixed fraction arithmetic block.
// Used by the multiplier, the divider and the top-level sequencer.
package fra_pkg;

  // Width of the result fields and of the divider datapath.
  localparam int unsigned DW = 62;
  // Width of the multiplier operands.
  localparam int unsigned MW = 32;
  // Width of the divider bit counter.
  localparam int unsigned CW = $clog2(DW);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_NORM_GO,
    S_NORM_WT,
    S_GCD_GO,
    S_GCD_WT,
    S_RN_GO,
    S_RN_WT,
    S_RD_GO,
    S_RD_WT,
    S_OUT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic          done;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- src/fra_mul.sv -----
// Registered signed multiplier shared by all product steps.
// Depends on fra_pkg for the operand width.
module fra_mul import fra_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [MW-1:0]       a_i,
  input  logic signed [MW-1:0]       b_i,
  output logic signed [2*MW-1:0]     p_o
);

  logic signed [2*MW-1:0] p_q;

  // One product per cycle, registered.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- src/fra_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on fra_pkg for widths and the request and response structs.
module fra_div import fra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, quo_q, dsr_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // Trial subtraction of the shifted partial remainder.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = ~diff[DW];
  end

  // Control next state.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- src/mixed_fraction_alu.sv -----
// Mixed fraction ALU: one item at a time. Products are formed in turn on the shared
// multiplier; the shared divider then serves to normalize if needed, for each
// Euclid step of the GCD and for the two reductions, with one more GCD state to
// end the search and an output state that holds the result until it is taken.
// A new transfer is accepted only after the result transfer has completed.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no result.
module mixed_fraction_alu import fra_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cmd[1:0], a_whole[17:2], a_num[32:18], a_den[47:33],
  // b_whole[63:48], b_num[78:64], b_den[93:79], zeros above
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // res_whole[61:0], res_num[123:62], res_den[185:124], status[187:186],
  // zeros above
  output logic [191:0] m_axis_tdata_o
);

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : v;
  endfunction

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  cmd_e                  cmd_q;
  logic signed [15:0]    aw_q, bw_q;
  logic [14:0]           an_q, ad_q, bn_q, bd_q;
  logic signed [MW-1:0]  ia_q, ib_q;
  logic signed [DW-1:0]  whole_q, num_q, den_q;
  logic [DW-1:0]         x_q, y_q;
  status_e               status_q;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic signed [DW-1:0]   p62;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic        in_fire;
  logic [14:0] in_ad, in_bd;
  logic        in_zden;
  logic        divz;

  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign in_ad   = s_axis_tdata_i[47:33];
  assign in_bd   = s_axis_tdata_i[93:79];
  assign in_zden = (in_ad == '0) || (in_bd == '0);
  assign p62     = mul_p[DW-1:0];
  assign divz    = (step_q == 3'd3) && (cmd_q == CMD_DIV) && (ib_q == '0);

  fra_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (s_axis_tvalid_i) state_d = in_zden ? S_OUT : S_MUL;
      S_MUL: begin
        if (divz) begin
          state_d = S_OUT;
        end else if (step_q == 3'd6) begin
          state_d = (num_q > p62) ? S_NORM_GO : S_GCD_GO;
        end
      end
      S_NORM_GO: state_d = S_NORM_WT;
      S_NORM_WT: if (div_rsp.done) state_d = S_GCD_GO;
      S_GCD_GO:  state_d = (y_q == '0) ? S_RN_GO : S_GCD_WT;
      S_GCD_WT:  if (div_rsp.done) state_d = S_GCD_GO;
      S_RN_GO:   state_d = S_RN_WT;
      S_RN_WT:   if (div_rsp.done) state_d = S_RD_GO;
      S_RD_GO:   state_d = S_RD_WT;
      S_RD_WT:   if (div_rsp.done) state_d = S_OUT;
      S_OUT:     if (m_axis_tready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, divider request and multiplier operands.
  always_comb begin
    s_axis_tready_o  = (state_q == S_IDLE);
    m_axis_tvalid_o  = (state_q == S_OUT);
    div_req.start    = 1'b0;
    div_req.dividend = mag(num_q);
    div_req.divisor  = x_q;
    case (state_q)
      S_NORM_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = mag(den_q);
      end
      S_GCD_GO: begin
        div_req.start    = (y_q != '0);
        div_req.dividend = x_q;
        div_req.divisor  = y_q;
      end
      S_RN_GO:   div_req.start = 1'b1;
      S_RD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag(den_q);
      end
      default:   div_req.start = 1'b0;
    endcase
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      3'd0: begin
        mul_a = MW'(aw_q);
        mul_b = MW'({1'b0, ad_q});
      end
      3'd1: begin
        mul_a = MW'(bw_q);
        mul_b = MW'({1'b0, bd_q});
      end
      3'd3: begin
        case (cmd_q)
          CMD_MUL: begin
            mul_a = ia_q;
            mul_b = ib_q;
          end
          CMD_DIV: begin
            mul_a = ia_q;
            mul_b = MW'({1'b0, bd_q});
          end
          default: begin
            mul_a = MW'({1'b0, an_q});
            mul_b = MW'({1'b0, bd_q});
          end
        endcase
      end
      3'd4: begin
        mul_a = MW'({1'b0, bn_q});
        mul_b = MW'({1'b0, ad_q});
      end
      3'd5: begin
        mul_a = MW'({1'b0, ad_q});
        mul_b = (cmd_q == CMD_DIV) ? ib_q : MW'({1'b0, bd_q});
      end
      default: mul_a = '0;
    endcase
  end

  // Step counter for the product phase.
  always_comb begin
    step_d = (state_q == S_MUL) ? step_q + 3'd1 : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Operand capture and result datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_q <= cmd_e'(s_axis_tdata_i[1:0]);
          aw_q  <= s_axis_tdata_i[17:2];
          an_q  <= s_axis_tdata_i[32:18];
          ad_q  <= in_ad;
          bw_q  <= s_axis_tdata_i[63:48];
          bn_q  <= s_axis_tdata_i[78:64];
          bd_q  <= in_bd;
          status_q <= in_zden ? ST_ZDEN : ST_OK;
          num_q <= '0;
          den_q <= '0;
          case (cmd_e'(s_axis_tdata_i[1:0]))
            CMD_ADD: whole_q <= DW'($signed(s_axis_tdata_i[17:2]))
                              + DW'($signed(s_axis_tdata_i[63:48]));
            CMD_SUB: whole_q <= DW'($signed(s_axis_tdata_i[17:2]))
                              - DW'($signed(s_axis_tdata_i[63:48]));
            default: whole_q <= '0;
          endcase
          if (in_zden) whole_q <= '0;
        end
      end
      S_MUL: begin
        case (step_q)
          3'd1: ia_q <= mul_p[MW-1:0] + MW'({1'b0, an_q});
          3'd2: ib_q <= mul_p[MW-1:0] + MW'({1'b0, bn_q});
          3'd3: begin
            if (divz) begin
              status_q <= ST_DIVZ;
              whole_q  <= '0;
            end
          end
          3'd4: num_q <= p62;
          3'd5: begin
            if (cmd_q == CMD_ADD) num_q <= num_q + p62;
            else if (cmd_q == CMD_SUB) num_q <= num_q - p62;
          end
          3'd6: begin
            den_q <= p62;
            x_q   <= mag(num_q);
            y_q   <= mag(p62);
          end
          default: x_q <= x_q;
        endcase
      end
      S_NORM_WT: begin
        if (div_rsp.done) begin
          whole_q <= whole_q + ((num_q[DW-1] ^ den_q[DW-1]) ?
                                DW'(-div_rsp.quo) : div_rsp.quo);
          num_q   <= num_q[DW-1] ? DW'(-div_rsp.rem) : div_rsp.rem;
          x_q     <= div_rsp.rem;
        end
      end
      S_GCD_WT: begin
        if (div_rsp.done) begin
          x_q <= y_q;
          y_q <= div_rsp.rem;
        end
      end
      S_RN_WT: begin
        if (div_rsp.done) num_q <= num_q[DW-1] ? DW'(-div_rsp.quo) : div_rsp.quo;
      end
      S_RD_WT: begin
        if (div_rsp.done) den_q <= den_q[DW-1] ? DW'(-div_rsp.quo) : div_rsp.quo;
      end
      default: x_q <= x_q;
    endcase
  end

  assign m_axis_tdata_o = {4'b0, status_q, den_q, num_q, whole_q};

`ifndef SYNTHESIS
  // Input and output sides are never open at the same time.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output handshake open together");

  // A divider result only arrives while the sequencer waits for one.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_NORM_WT || state_q == S_GCD_WT ||
                      state_q == S_RN_WT || state_q == S_RD_WT))
    else $error("divider finished outside a wait state");

  // A good result never carries a zero denominator.
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status_q == ST_OK) |-> (den_q != '0))
    else $error("zero denominator on a good result");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for mixed_fraction_alu: drives operand pairs on the input
// stream and compares every result transfer against an in-bench rational predictor.
// Depends on fra_pkg for the command and status codes.
module tb_top;
  import fra_pkg::*;

  // Field layout of one result: sign-kept rational in mixed form.
  typedef struct {
    logic [61:0] whole;
    logic [61:0] num;
    logic [61:0] den;
    status_e     status;
  } frac_res_t;

  localparam int unsigned CYCLE_LIMIT = 40000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // cmd, a_whole, a_num, a_den, b_whole, b_num, b_den, zeros above
  logic [95:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // res_whole, res_num, res_den, status, zeros above
  logic [191:0] m_axis_tdata_o;

  frac_res_t   pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;

  mixed_fraction_alu DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // Gap length: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 80);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Computes the normalized and reduced mixed-number result of one operation.
  function automatic frac_res_t compute_fraction(cmd_e cmd, logic signed [15:0] aw_i,
      logic [14:0] an_i, logic [14:0] ad_i, logic signed [15:0] bw_i,
      logic [14:0] bn_i, logic [14:0] bd_i);
    frac_res_t r;
    longint aw, an, ad, bw, bn, bd, ia, ib, whole, num, den, q;
    longint unsigned g;
    aw = aw_i; an = an_i; ad = ad_i;
    bw = bw_i; bn = bn_i; bd = bd_i;
    r.whole = '0;
    r.num = '0;
    r.den = '0;
    r.status = ST_OK;
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    ia = an + aw * ad;
    ib = bn + bw * bd;
    whole = 0;
    case (cmd)
      CMD_ADD: begin
        whole = aw + bw;
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      CMD_SUB: begin
        whole = aw - bw;
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      CMD_MUL: begin
        num = ia * ib;
        den = ad * bd;
      end
      default: begin
        if (ib == 0) begin
          r.status = ST_DIVZ;
          return r;
        end
        num = ia * bd;
        den = ad * ib;
      end
    endcase
    // A numerator greater than the denominator moves its truncated quotient into the whole part.
    if (num > den) begin
      q = num / den;
      whole += q;
      num -= den * q;
    end
    g = euclid_gcd(magnitude(num), magnitude(den));
    if (g != 0) begin
      num /= longint'(g);
      den /= longint'(g);
    end
    r.whole = whole[61:0];
    r.num = num[61:0];
    r.den = den[61:0];
    return r;
  endfunction

  // Sends one operand pair and records its expected result once the transfer happens.
  task automatic send_operands(cmd_e cmd, logic [15:0] aw, logic [14:0] an,
      logic [14:0] ad, logic [15:0] bw, logic [14:0] bn, logic [14:0] bd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, bd, bn, bw, ad, an, aw, cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(compute_fraction(cmd, aw, an, ad, bw, bn, bd));
    items_sent++;
  endtask

  // A zero denominator on either side, for every operation.
  task automatic test_zero_denominator();
    send_operands(CMD_ADD, 16'd3, 15'd1, 15'd0, 16'd2, 15'd1, 15'd4);
    send_operands(CMD_SUB, 16'd3, 15'd1, 15'd5, 16'd2, 15'd1, 15'd0);
    send_operands(CMD_MUL, 16'h8000, 15'h7FFF, 15'd0, 16'h7FFF, 15'h7FFF, 15'd0);
    send_operands(CMD_DIV, 16'd0, 15'd0, 15'd0, 16'd0, 15'd0, 15'd0);
  endtask

  // Division by an operand whose value is zero.
  task automatic test_divide_by_zero();
    send_operands(CMD_DIV, 16'd7, 15'd2, 15'd3, 16'd0, 15'd0, 15'd9);
    send_operands(CMD_DIV, 16'd1, 15'd1, 15'd2, 16'hFFFF, 15'd5, 15'd5);
    send_operands(CMD_DIV, 16'h8000, 15'h7FFF, 15'h7FFF, 16'hFFFE, 15'd6, 15'd3);
  endtask

  // Extreme field values, zero numerators and negative denominators in divide.
  task automatic test_extremes();
    cmd_e c;
    for (int k = 0; k < 4; k++) begin
      c = cmd_e'(k);
      send_operands(c, 16'h7FFF, 15'h7FFF, 15'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF);
      send_operands(c, 16'h8000, 15'h7FFF, 15'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF);
      send_operands(c, 16'h8000, 15'd0, 15'd1, 16'h7FFF, 15'h7FFE, 15'h7FFF);
    end
    send_operands(CMD_ADD, 16'd0, 15'd0, 15'd7, 16'd0, 15'd0, 15'd3);
    send_operands(CMD_MUL, 16'd0, 15'd0, 15'd7, 16'hFFFB, 15'd2, 15'd9);
    send_operands(CMD_DIV, 16'd2, 15'd1, 15'd3, 16'hFFFD, 15'd1, 15'd4);
    send_operands(CMD_DIV, 16'hFFFF, 15'd0, 15'd1, 16'hFFFF, 15'd1, 15'd2);
  endtask

  // One ordinary case per operation.
  task automatic test_each_operation();
    send_operands(CMD_ADD, 16'd1, 15'd1, 15'd2, 16'd2, 15'd2, 15'd3);
    send_operands(CMD_SUB, 16'd1, 15'd1, 15'd2, 16'd2, 15'd2, 15'd3);
    send_operands(CMD_MUL, 16'd1, 15'd1, 15'd2, 16'd2, 15'd2, 15'd3);
    send_operands(CMD_DIV, 16'd1, 15'd1, 15'd2, 16'd2, 15'd2, 15'd3);
  endtask

  // Random operands: full range, small values, and occasional zero fields.
  task automatic test_random_operands(int unsigned count);
    logic [15:0] aw, bw;
    logic [14:0] an, ad, bn, bd;
    int unsigned kind;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      aw = $urandom; bw = $urandom;
      an = $urandom; ad = $urandom; bn = $urandom; bd = $urandom;
      if (kind < 4) begin
        aw = $signed(10'($urandom)) >>> 3;
        bw = $signed(10'($urandom)) >>> 3;
        an = $urandom_range(0, 60); ad = $urandom_range(1, 60);
        bn = $urandom_range(0, 60); bd = $urandom_range(1, 60);
      end else if (kind == 4) begin
        an = 0;
        bn = 0;
        bw = $urandom_range(0, 1) ? 16'd0 : bw;
      end else if (kind == 5 && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) ad = 0;
        else bd = 0;
      end
      if (ad == 0 && kind != 5) ad = 1;
      if (bd == 0 && kind != 5) bd = 1;
      send_operands(cmd_e'($urandom_range(0, 3)), aw, an, ad, bw, bn, bd);
    end
  endtask

  // Receiver stalls at random, with stretches of steady acceptance.
  always @(posedge clk_i) begin
    if (cycle_count % 4000 < 1500) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 20) == 0);
    end
  end

  // Compare each result transfer against the oldest pending prediction.
  always @(posedge clk_i) begin
    frac_res_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("Result transfer with no pending prediction: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata_o[61:0] !== exp_r.whole) begin
          $error("res_whole: expected %h, actual %h", exp_r.whole, m_axis_tdata_o[61:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[123:62] !== exp_r.num) begin
          $error("res_num: expected %h, actual %h", exp_r.num, m_axis_tdata_o[123:62]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[185:124] !== exp_r.den) begin
          $error("res_den: expected %h, actual %h", exp_r.den, m_axis_tdata_o[185:124]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[187:186] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tdata_o[187:186]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_denominator();
    test_divide_by_zero();
    test_extremes();
    test_each_operation();
    test_random_operands(650);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/fra_pkg.sv
src/fra_mul.sv
src/fra_div.sv
src/mixed_fraction_alu.sv
tb/tb_top.sv
